// File: rtl/hcc_pkg.sv
// Shared types, constants and modulo-26 helpers for the 2x2 Hill cipher core.
package hcc_pkg;

  localparam int unsigned LetterW    = 5;
  localparam int unsigned Modulus    = 26;
  localparam int unsigned CfgIdxW    = 3;
  localparam int unsigned CfgDataW   = 5;
  localparam int unsigned QueueDepth = 2;
  // floor(v / 26) == (v * Recip26) >> 16 for every v below 2048
  localparam int unsigned Recip26    = 2521;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_KEY_R0C0 = 3'd0,
    CFG_KEY_R0C1 = 3'd1,
    CFG_KEY_R1C0 = 3'd2,
    CFG_KEY_R1C1 = 3'd3,
    CFG_DECRYPT  = 3'd4
  } cfg_idx_e;

  // Key entries already reduced modulo 26
  typedef struct packed {
    logic [LetterW-1:0] m00;
    logic [LetterW-1:0] m01;
    logic [LetterW-1:0] m10;
    logic [LetterW-1:0] m11;
    logic               decrypt;
  } key_t;

  // Queue entry from front end to back end
  typedef struct packed {
    logic               odd;
    logic               eom;
    logic [LetterW-1:0] x;
    logic [LetterW-1:0] y;
  } cmd_t;

  function automatic logic [LetterW-1:0] red5(logic [LetterW-1:0] v);
    logic [LetterW-1:0] r;
    r = (v >= LetterW'(Modulus)) ? v - LetterW'(Modulus) : v;
    return r;
  endfunction

  function automatic logic [LetterW-1:0] mod26(logic [10:0] v);
    logic [22:0] p;
    logic [6:0]  q;
    logic [11:0] qm;
    logic [11:0] r;
    p  = 23'(v) * 23'(Recip26);
    q  = p[22:16];
    qm = 12'(q) * 12'(Modulus);
    r  = 12'(v) - qm;
    return r[LetterW-1:0];
  endfunction

  // Returns {valid, inverse}; valid is low when no inverse exists
  function automatic logic [LetterW:0] inv26(logic [LetterW-1:0] d);
    logic [LetterW:0] r;
    case (d)
      5'd1:    r = {1'b1, 5'd1};
      5'd3:    r = {1'b1, 5'd9};
      5'd5:    r = {1'b1, 5'd21};
      5'd7:    r = {1'b1, 5'd15};
      5'd9:    r = {1'b1, 5'd3};
      5'd11:   r = {1'b1, 5'd19};
      5'd15:   r = {1'b1, 5'd7};
      5'd17:   r = {1'b1, 5'd23};
      5'd19:   r = {1'b1, 5'd11};
      5'd21:   r = {1'b1, 5'd5};
      5'd23:   r = {1'b1, 5'd17};
      5'd25:   r = {1'b1, 5'd25};
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// File: rtl/hcc_front.sv
// Front end: accepts letters, pairs them up and queues pair or odd-drop commands.
module hcc_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [hcc_pkg::LetterW-1:0]  letter_in_i,
  input  logic                         end_of_message_i,
  input  logic                         q_full_i,
  output logic                         q_push_o,
  output hcc_pkg::cmd_t                q_data_o
);

  logic                        holding_q;
  logic [hcc_pkg::LetterW-1:0] held_q;
  logic                        accept;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;

  // A second letter completes a pair; a lone final letter becomes a drop marker
  assign q_push_o      = accept && (holding_q || end_of_message_i);
  assign q_data_o.odd  = !holding_q;
  assign q_data_o.eom  = end_of_message_i;
  assign q_data_o.x    = held_q;
  assign q_data_o.y    = hcc_pkg::red5(letter_in_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      holding_q <= 1'b0;
    end else if (accept) begin
      if (holding_q) begin
        holding_q <= 1'b0;
      end else if (!end_of_message_i) begin
        holding_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && !holding_q) begin
      held_q <= hcc_pkg::red5(letter_in_i);
    end
  end

endmodule

// File: rtl/hcc_fifo.sv
// Command queue between front end and back end, show-ahead read.
module hcc_fifo #(
  parameter int unsigned Depth = hcc_pkg::QueueDepth
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  hcc_pkg::cmd_t push_data_i,
  input  logic          pop_i,
  output hcc_pkg::cmd_t pop_data_o,
  output logic          full_o,
  output logic          empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  hcc_pkg::cmd_t  mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q;
  logic [PtrW-1:0] rd_ptr_q;
  logic [CntW-1:0] cnt_q;

  assign full_o     = (cnt_q == CntW'(Depth));
  assign empty_o    = (cnt_q == '0);
  assign pop_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// File: rtl/hcc_back.sv
// Back end: shared multiply-reduce unit that inverts the key and transforms pairs.
module hcc_back (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  hcc_pkg::key_t                key_i,
  input  logic                         q_empty_i,
  input  hcc_pkg::cmd_t                q_data_i,
  output logic                         q_pop_o,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [hcc_pkg::LetterW-1:0]  letter_out_o,
  output logic                         last_out_o,
  output logic                         odd_dropped_o,
  output logic                         key_error_o
);

  localparam int unsigned W = hcc_pkg::LetterW;

  typedef enum logic [2:0] {
    B_IDLE,
    B_MUL,
    B_RED,
    B_EMIT0,
    B_EMIT1
  } state_e;

  typedef enum logic [2:0] {
    OP_DET,
    OP_INV00,
    OP_INV01,
    OP_INV10,
    OP_INV11,
    OP_OUT0,
    OP_OUT1
  } op_e;

  state_e       state_q;
  op_e          op_q;
  logic [10:0]  sum_q;
  logic [W-1:0] dinv_q;
  logic [W-1:0] n00_q, n01_q, n10_q, n11_q;
  logic [W-1:0] x_q, y_q;
  logic [W-1:0] l0_q, l1_q;
  logic         last_q, odd_q, err_q;
  logic         out_valid_q;
  logic [W-1:0] letter_q;
  logic         last_out_q, odd_out_q, err_out_q;

  logic [W:0]   a, c;
  logic [W-1:0] b, d;
  logic [W:0]   neg01, neg10;
  logic [10:0]  sum_d;
  logic [W-1:0] red;
  logic [W:0]   inv;
  logic         can_push;
  logic         emit;

  assign neg01 = (W + 1)'(hcc_pkg::Modulus) - (W + 1)'(key_i.m01);
  assign neg10 = (W + 1)'(hcc_pkg::Modulus) - (W + 1)'(key_i.m10);

  // Operand select; the minus terms use 26 - m, which reduces to the same residue
  always_comb begin
    a = '0;
    b = '0;
    c = '0;
    d = '0;
    case (op_q)
      OP_DET: begin
        a = (W + 1)'(key_i.m00);
        b = key_i.m11;
        c = neg01;
        d = key_i.m10;
      end
      OP_INV00: begin
        a = (W + 1)'(key_i.m11);
        b = dinv_q;
      end
      OP_INV01: begin
        a = neg01;
        b = dinv_q;
      end
      OP_INV10: begin
        a = neg10;
        b = dinv_q;
      end
      OP_INV11: begin
        a = (W + 1)'(key_i.m00);
        b = dinv_q;
      end
      OP_OUT0: begin
        a = (W + 1)'(n00_q);
        b = x_q;
        c = (W + 1)'(n01_q);
        d = y_q;
      end
      OP_OUT1: begin
        a = (W + 1)'(n10_q);
        b = x_q;
        c = (W + 1)'(n11_q);
        d = y_q;
      end
      default: begin
        a = '0;
      end
    endcase
  end

  assign sum_d    = (11'(a) * 11'(b)) + (11'(c) * 11'(d));
  assign red      = hcc_pkg::mod26(sum_q);
  assign inv      = hcc_pkg::inv26(red);
  assign can_push = !out_valid_q || !out_stall_i;
  assign emit     = ((state_q == B_EMIT0) || (state_q == B_EMIT1)) && can_push;
  assign q_pop_o  = (state_q == B_IDLE) && !q_empty_i;

  assign out_valid_o   = out_valid_q;
  assign letter_out_o  = letter_q;
  assign last_out_o    = last_out_q;
  assign odd_dropped_o = odd_out_q;
  assign key_error_o   = err_out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      op_q        <= OP_DET;
      sum_q       <= '0;
      dinv_q      <= '0;
      n00_q       <= '0;
      n01_q       <= '0;
      n10_q       <= '0;
      n11_q       <= '0;
      x_q         <= '0;
      y_q         <= '0;
      l0_q        <= '0;
      l1_q        <= '0;
      last_q      <= 1'b0;
      odd_q       <= 1'b0;
      err_q       <= 1'b0;
      out_valid_q <= 1'b0;
      letter_q    <= '0;
      last_out_q  <= 1'b0;
      odd_out_q   <= 1'b0;
      err_out_q   <= 1'b0;
    end else begin
      if (out_valid_q && !out_stall_i && !emit) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        B_IDLE: begin
          if (!q_empty_i) begin
            if (q_data_i.odd) begin
              l1_q    <= '0;
              last_q  <= 1'b1;
              odd_q   <= 1'b1;
              err_q   <= 1'b0;
              state_q <= B_EMIT1;
            end else begin
              last_q  <= q_data_i.eom;
              x_q     <= q_data_i.x;
              y_q     <= q_data_i.y;
              odd_q   <= 1'b0;
              err_q   <= 1'b0;
              n00_q   <= key_i.m00;
              n01_q   <= key_i.m01;
              n10_q   <= key_i.m10;
              n11_q   <= key_i.m11;
              op_q    <= key_i.decrypt ? OP_DET : OP_OUT0;
              state_q <= B_MUL;
            end
          end
        end
        B_MUL: begin
          sum_q   <= sum_d;
          state_q <= B_RED;
        end
        B_RED: begin
          case (op_q)
            OP_DET: begin
              if (inv[W]) begin
                dinv_q  <= inv[W-1:0];
                op_q    <= OP_INV00;
                state_q <= B_MUL;
              end else begin
                // singular key: one error result, pair consumed
                l1_q    <= '0;
                err_q   <= 1'b1;
                state_q <= B_EMIT1;
              end
            end
            OP_INV00: begin
              n00_q   <= red;
              op_q    <= OP_INV01;
              state_q <= B_MUL;
            end
            OP_INV01: begin
              n01_q   <= red;
              op_q    <= OP_INV10;
              state_q <= B_MUL;
            end
            OP_INV10: begin
              n10_q   <= red;
              op_q    <= OP_INV11;
              state_q <= B_MUL;
            end
            OP_INV11: begin
              n11_q   <= red;
              op_q    <= OP_OUT0;
              state_q <= B_MUL;
            end
            OP_OUT0: begin
              l0_q    <= red;
              op_q    <= OP_OUT1;
              state_q <= B_MUL;
            end
            OP_OUT1: begin
              l1_q    <= red;
              state_q <= B_EMIT0;
            end
            default: begin
              state_q <= B_IDLE;
            end
          endcase
        end
        B_EMIT0: begin
          if (can_push) begin
            out_valid_q <= 1'b1;
            letter_q    <= l0_q;
            last_out_q  <= 1'b0;
            odd_out_q   <= 1'b0;
            err_out_q   <= 1'b0;
            state_q     <= B_EMIT1;
          end
        end
        B_EMIT1: begin
          if (can_push) begin
            out_valid_q <= 1'b1;
            letter_q    <= l1_q;
            last_out_q  <= last_q;
            odd_out_q   <= odd_q;
            err_out_q   <= err_q;
            state_q     <= B_IDLE;
          end
        end
        default: begin
          state_q <= B_IDLE;
        end
      endcase
    end
  end

endmodule

// File: rtl/hill_cipher_2x2_core.sv
// Top level of the 2x2 Hill cipher core: key registers, front end, queue, back end.
// Letters (0..25, larger codes reduced mod 26) enter at one per cycle while the
// command queue has room; the first letter of a pair is held and the second
// queues the pair. The back end works one queued command at a time through a
// shared multiply-and-reduce unit that forms each product in state B_MUL and
// reduces it in B_RED: for an encrypted pair the two letters, for a decrypted
// pair first the determinant and four inverse-key entries, then the letters.
// A singular key yields one error result, an odd-drop marker one result with
// no product; output stalls hold the back end in its emit states. Sustained
// throughput is set by the back end. Key and mode registers are read live by
// the back end and must be written only while the core is idle.
module hill_cipher_2x2_core #(
  parameter int unsigned QueueDepth = hcc_pkg::QueueDepth
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [hcc_pkg::LetterW-1:0]   letter_in_i,
  input  logic                          end_of_message_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [hcc_pkg::LetterW-1:0]   letter_out_o,
  output logic                          last_out_o,
  output logic                          odd_dropped_o,
  output logic                          key_error_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [hcc_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [hcc_pkg::CfgDataW-1:0]  cfg_data_i
);

  logic [hcc_pkg::LetterW-1:0] key_r0c0_q, key_r0c1_q, key_r1c0_q, key_r1c1_q;
  logic                        decrypt_q;
  hcc_pkg::key_t               key;
  hcc_pkg::cmd_t               push_data, pop_data;
  logic                        q_push, q_pop, q_full, q_empty;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_r0c0_q <= hcc_pkg::LetterW'(1);
      key_r0c1_q <= '0;
      key_r1c0_q <= '0;
      key_r1c1_q <= hcc_pkg::LetterW'(1);
      decrypt_q  <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        hcc_pkg::CFG_KEY_R0C0: key_r0c0_q <= cfg_data_i[hcc_pkg::LetterW-1:0];
        hcc_pkg::CFG_KEY_R0C1: key_r0c1_q <= cfg_data_i[hcc_pkg::LetterW-1:0];
        hcc_pkg::CFG_KEY_R1C0: key_r1c0_q <= cfg_data_i[hcc_pkg::LetterW-1:0];
        hcc_pkg::CFG_KEY_R1C1: key_r1c1_q <= cfg_data_i[hcc_pkg::LetterW-1:0];
        hcc_pkg::CFG_DECRYPT:  decrypt_q  <= cfg_data_i[0];
        default: begin
          decrypt_q <= decrypt_q;
        end
      endcase
    end
  end

  assign key.m00     = hcc_pkg::red5(key_r0c0_q);
  assign key.m01     = hcc_pkg::red5(key_r0c1_q);
  assign key.m10     = hcc_pkg::red5(key_r1c0_q);
  assign key.m11     = hcc_pkg::red5(key_r1c1_q);
  assign key.decrypt = decrypt_q;

  hcc_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .letter_in_i      (letter_in_i),
    .end_of_message_i (end_of_message_i),
    .q_full_i         (q_full),
    .q_push_o         (q_push),
    .q_data_o         (push_data)
  );

  hcc_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (push_data),
    .pop_i       (q_pop),
    .pop_data_o  (pop_data),
    .full_o      (q_full),
    .empty_o     (q_empty)
  );

  hcc_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .key_i         (key),
    .q_empty_i     (q_empty),
    .q_data_i      (pop_data),
    .q_pop_o       (q_pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .letter_out_o  (letter_out_o),
    .last_out_o    (last_out_o),
    .odd_dropped_o (odd_dropped_o),
    .key_error_o   (key_error_o)
  );

endmodule

// File: rtl/hcc_checker.sv
// Port-level checker for the 2x2 Hill cipher core, bound to the top level.
module hcc_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         out_valid_o,
  input logic                         out_stall_i,
  input logic [hcc_pkg::LetterW-1:0]  letter_out_o,
  input logic                         last_out_o,
  input logic                         odd_dropped_o,
  input logic                         key_error_o
);

  // Stalled output transaction holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(letter_out_o) &&
    $stable(last_out_o) && $stable(odd_dropped_o) && $stable(key_error_o))
    else $error("output transaction changed while stalled");

  a_letter_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> letter_out_o < hcc_pkg::LetterW'(hcc_pkg::Modulus))
    else $error("result letter out of range");

  a_odd_marker: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && odd_dropped_o |->
    letter_out_o == '0 && last_out_o && !key_error_o)
    else $error("malformed odd-drop marker");

  a_key_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && key_error_o |-> letter_out_o == '0 && !odd_dropped_o)
    else $error("malformed key-error result");

endmodule

bind hill_cipher_2x2_core hcc_checker u_hcc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .letter_out_o  (letter_out_o),
  .last_out_o    (last_out_o),
  .odd_dropped_o (odd_dropped_o),
  .key_error_o   (key_error_o)
);
